// File: src/fde_pkg.sv
// Shared types, register codes and a saturation helper for the feedback delay echo.
package fde_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 7;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Scaling shift for gains given in 128ths, and the shortest delay allowed.
  localparam int GAIN_SHIFT = 7;
  localparam int MIN_DELAY  = 100;

  localparam logic [1:0] REG_DELAY_TIME    = 2'd0;
  localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [1:0] REG_WET_MIX       = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] delay_time;
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] wet_mix;
  } cfg_t;

  // Clamp an 18-bit signed sum to the 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W+1:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: src/fde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fde_cfg.sv
// APB-style register file holding delay time, feedback gain and wet mix.
module fde_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fde_pkg::CFG_AW-1:0]  paddr,
  input  logic [fde_pkg::CFG_DW-1:0]  pwdata,
  output logic [fde_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output fde_pkg::cfg_t               cfg
);
  import fde_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DELAY_TIME:    cfg_nxt.delay_time    = pwdata[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: cfg_nxt.feedback_gain = pwdata[GAIN_W-1:0];
        REG_WET_MIX:       cfg_nxt.wet_mix       = pwdata[GAIN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELAY_TIME:    prdata = CFG_DW'(cfg_r.delay_time);
      REG_FEEDBACK_GAIN: prdata = CFG_DW'(cfg_r.feedback_gain);
      REG_WET_MIX:       prdata = CFG_DW'(cfg_r.wet_mix);
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: src/fde_core.sv
// Echo datapath: ring memory, write pointer, clearing pass and the two-stage pipeline.
module fde_core #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fde_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fde_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fde_pkg::SAMPLE_W-1:0] out_sample_out
);
  import fde_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = AW + GAIN_W + 1;

  // Clearing pass after reset.
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [AW-1:0] wp_r, wp_nxt;

  // Stage 1: sample waiting for its ring read.
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_bypass_r;
  logic [AW-1:0]              s1_wp_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic          in_fire, bypass, out_free, s1_adv;
  logic [LW-1:0] len_full;
  logic [AW-1:0] len_raw, len;
  logic [AW:0]   rd_wrap;
  logic [AW-1:0] rd_addr;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic signed [SAMPLE_W-1:0]   old_s;
  logic signed [SAMPLE_W+7:0]   prod_fb, prod_wet;
  logic signed [SAMPLE_W:0]     sc_fb, sc_wet;
  logic signed [SAMPLE_W+1:0]   sum_fb, sum_wet;
  logic signed [SAMPLE_W-1:0]   stored, y;

  assign bypass   = (cfg.delay_time == '0);
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !clr_busy_r && (!s1_valid_r || out_free);
  assign in_fire  = in_valid && in_ready;

  // Delay length never reaches RING_DEPTH, so it fits the pointer width.
  assign len_full = (LW'(cfg.delay_time) * LW'(RING_DEPTH)) >> GAIN_SHIFT;
  assign len_raw  = len_full[AW-1:0];
  assign len      = (len_raw < AW'(MIN_DELAY)) ? AW'(MIN_DELAY) : len_raw;
  assign rd_wrap  = {1'b0, wp_r} + (AW+1)'(RING_DEPTH) - {1'b0, len};
  assign rd_addr  = (wp_r >= len) ? (wp_r - len) : rd_wrap[AW-1:0];

  always_comb begin
    wp_nxt = wp_r;
    if (in_fire && !bypass) begin
      wp_nxt = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(RING_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
        clr_addr_nxt = '0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Gains are unsigned 7-bit; the arithmetic shift floors toward minus infinity.
  assign old_s    = $signed(ram_rdata);
  assign prod_fb  = old_s * $signed({1'b0, cfg.feedback_gain});
  assign prod_wet = old_s * $signed({1'b0, cfg.wet_mix});
  assign sc_fb    = prod_fb[SAMPLE_W+7:GAIN_SHIFT];
  assign sc_wet   = prod_wet[SAMPLE_W+7:GAIN_SHIFT];
  assign sum_fb   = (SAMPLE_W+2)'(s1_x_r) + (SAMPLE_W+2)'(sc_fb);
  assign sum_wet  = (SAMPLE_W+2)'(s1_x_r) + (SAMPLE_W+2)'(sc_wet);
  assign stored   = sat16(sum_fb);
  assign y        = s1_bypass_r ? s1_x_r : sat16(sum_wet);

  assign ram_we    = clr_busy_r || (s1_adv && !s1_bypass_r);
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_wp_r;
  assign ram_wdata = clr_busy_r ? '0 : stored;

  fde_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      wp_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wp_r        <= wp_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bypass_r <= bypass;
      s1_wp_r     <= wp_r;
      s1_x_r      <= in_sample_in;
    end
    if (s1_adv) begin
      out_sample_r <= y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("input beat accepted during ring clearing");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && in_fire) |-> (ram_waddr != rd_addr))
    else $error("ring write and read hit the same entry");

  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> $stable(ram_rdata))
    else $error("ring read data changed under a stalled stage");

  a_bypass_keeps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && bypass) |=> $stable(wp_r))
    else $error("write pointer moved on a bypass beat");

endmodule

// File: src/feedback_delay_echo.sv
// A beat accepted at the input waits in stage 1 for its ring read, then moves into the
// output register once that register is free and is offered on the output from there.
// Throughput: one beat per cycle while the output side accepts and no clearing pass runs;
// the ring read is issued at accept, its write-back when the beat leaves the first stage.
// Reset (synchronous, active low) zeroes the registers, the pointer and the pipeline, then
// clears all RING_DEPTH ring entries, one entry per cycle, with in_ready held low.
module feedback_delay_echo #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fde_pkg::CFG_AW-1:0]          paddr,
  input  logic [fde_pkg::CFG_DW-1:0]          pwdata,
  output logic [fde_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fde_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fde_pkg::SAMPLE_W-1:0] out_sample_out
);
  import fde_pkg::*;

  cfg_t cfg;

  fde_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fde_core #(
    .RING_DEPTH (RING_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

endmodule

// File: test/feedback_delay_echo_tb.sv
// Self-checking testbench for the feedback delay echo: random and directed samples checked
// against a predicted ring.
`timescale 1ns / 100ps

module feedback_delay_echo_tb;
  import fde_pkg::*;

  localparam int RING_DEPTH = 8192;
  localparam int PTR_W      = 13;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;

  // Predicted state of the echo: ring contents, write pointer and register values.
  logic signed [SAMPLE_W-1:0] model_ring [RING_DEPTH];
  logic [PTR_W-1:0]           model_wptr;
  logic [GAIN_W-1:0]          model_delay;
  logic [GAIN_W-1:0]          model_feedback;
  logic [GAIN_W-1:0]          model_wet;

  logic signed [SAMPLE_W-1:0] pending_samples [$];
  logic signed [SAMPLE_W-1:0] expected_out_q [$];

  int   err_count = 0;
  logic in_took = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  logic [5:0]  stall_tick = '0;
  logic [15:0] stall_mask = 16'hffff;

  feedback_delay_echo #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > 32767) begin
      res = 16'sh7fff;
    end else if (v < -32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Works out the output sample for one input; outside bypass it also updates the predicted ring.
  function automatic logic signed [SAMPLE_W-1:0] echo_predict(
    input logic signed [SAMPLE_W-1:0] x
  );
    int unsigned dlen;
    logic [PTR_W-1:0] rd_idx;
    int old_s;
    int fb_term;
    int wet_term;
    if (model_delay == '0) begin
      return x;
    end
    dlen = (int'(model_delay) * RING_DEPTH) / 128;
    if (dlen < MIN_DELAY) begin
      dlen = MIN_DELAY;
    end
    dlen = dlen % RING_DEPTH;
    rd_idx = model_wptr - PTR_W'(dlen);
    old_s = model_ring[rd_idx];
    // Arithmetic shift on a signed product rounds toward minus infinity.
    fb_term  = (old_s * int'(model_feedback)) >>> GAIN_SHIFT;
    wet_term = (old_s * int'(model_wet)) >>> GAIN_SHIFT;
    model_ring[model_wptr] = clamp_sample(int'(x) + fb_term);
    model_wptr = model_wptr + 1'b1;
    return clamp_sample(int'(x) + wet_term);
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  // Input driver: bursts of random length with random gaps in between.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_sample_in <= pending_samples.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stalls follow a 16-bit mask, reloaded each time the 6-bit stall_tick wraps.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) begin
      stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
    out_ready <= stall_mask[stall_tick[3:0]];
  end

  // Monitor: output beats are checked before the beat accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out_q.size() == 0) begin
          note_failure($sformatf("unexpected output beat, sample_out %0d", out_sample_out));
        end else if (out_sample_out !== expected_out_q[0]) begin
          note_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                 expected_out_q.pop_front(), out_sample_out));
        end else begin
          void'(expected_out_q.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        expected_out_q.push_back(echo_predict(in_sample_in));
      end
      in_took <= in_valid && in_ready;
    end
  end

  task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Writes a register with random junk in the unused upper bits, then reads back any used one.
  task automatic set_reg(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
    logic [CFG_DW-1:0] rdata;
    logic [GAIN_W-1:0] held;
    apb_access(1'b1, {idx, 2'b00}, {25'($urandom), val}, rdata);
    case (idx)
      REG_DELAY_TIME:    model_delay = val;
      REG_FEEDBACK_GAIN: model_feedback = val;
      REG_WET_MIX:       model_wet = val;
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      held = (idx == REG_DELAY_TIME) ? model_delay :
             (idx == REG_FEEDBACK_GAIN) ? model_feedback : model_wet;
      apb_access(1'b0, {idx, 2'b00}, '0, rdata);
      if (rdata !== {25'b0, held}) begin
        note_failure($sformatf("register %0d readback: expected %0d, got %0d",
                               idx, held, rdata));
      end
    end
  endtask

  // Holds off until every sample has gone through and the pipeline has drained.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) begin
      return 7'd127;
    end else if (r == 2) begin
      return 7'd0;
    end
    return 7'($urandom);
  endfunction

  initial begin
    logic [GAIN_W-1:0] dt;
    logic [GAIN_W-1:0] fb;
    logic [GAIN_W-1:0] wet;
    int n_items;
    int r;
    for (int i = 0; i < RING_DEPTH; i++) begin
      model_ring[i] = '0;
    end
    model_wptr = '0;
    model_delay = '0;
    model_feedback = '0;
    model_wet = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bypass keeps the sample as it is even with both gains at full scale.
    set_reg(REG_DELAY_TIME, 7'd0);
    set_reg(REG_FEEDBACK_GAIN, 7'd127);
    set_reg(REG_WET_MIX, 7'd127);
    set_reg(REG_UNUSED, 7'd5);
    pending_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                        16'sh5555, 16'shaaaa};
    wait_drained();

    // Shortest delay setting, raised to the minimum length; the ring still reads zeros.
    set_reg(REG_DELAY_TIME, 7'd1);
    pending_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555,
                        16'shaaaa, 16'sd16384, -16'sd16385, 16'sd100, -16'sd100, 16'sh7fff};
    wait_drained();

    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin dt = 7'd127; fb = 7'd127; wet = 7'd127; end
        1: begin dt = 7'd1;   fb = 7'd127; wet = 7'd127; end
        2: begin dt = 7'd2;   fb = 7'd0;   wet = 7'd127; end
        3: begin dt = 7'd0;   fb = pick_gain(); wet = pick_gain(); end
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            dt = 7'd0;
          end else if (r <= 5) begin
            dt = 7'($urandom_range(1, 2));
          end else if (r <= 7) begin
            dt = 7'($urandom_range(3, 12));
          end else begin
            dt = 7'($urandom_range(1, 127));
          end
          fb = pick_gain();
          wet = pick_gain();
        end
      endcase
      set_reg(REG_DELAY_TIME, dt);
      set_reg(REG_FEEDBACK_GAIN, fb);
      set_reg(REG_WET_MIX, wet);
      set_reg(REG_UNUSED, 7'($urandom));

      n_items = $urandom_range(45, 60);
      for (int j = 0; j < n_items; j++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          pending_samples.push_back(16'sh7fff);
        end else if (r == 1) begin
          pending_samples.push_back(16'sh8000);
        end else if (r == 2) begin
          pending_samples.push_back(16'($urandom_range(0, 255)) - 16'sd128);
        end else begin
          pending_samples.push_back(16'($urandom));
        end
      end
      // The sender stops here until the last expected sample has arrived.
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_out_q.size() == 0) begin
      $display("** feedback_delay_echo: PASSED **");
    end else begin
      $display("** feedback_delay_echo: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** feedback_delay_echo: FAILED **");
    $finish;
  end

endmodule
